// ----- src/bcgd_pkg.sv -----
// Shared types and constants for the button click gesture detector.
// No dependencies; the top level and its checker take names from here by scope.
`default_nettype none

package bcgd_pkg;

    // Width of the configuration write data (widest register)
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Register widths
    localparam int CLICK_MIN_W = 8;
    localparam int WINDOW_W    = 8;
    localparam int LONG_W      = 16;

    // Register reset values
    localparam logic [CLICK_MIN_W-1:0] CLICK_MIN_RESET = 8'd1;
    localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = 8'd10;
    localparam logic [LONG_W-1:0]      LONG_RESET      = 16'd40;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_MIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG      = 2'd2;

    // Input word kinds
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result gesture codes
    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SINGLE = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } gesture_t;

endpackage

`default_nettype wire

// ----- src/button_click_gesture_detector.sv -----
// Button click gesture detector: single click, double click and long press.
// Depends on bcgd_pkg for register indexes, widths and gesture codes.
//
//  channel   | ports                                          | direction
//  ----------+------------------------------------------------+----------
//  input     | s_valid s_ready s_action s_sample_first/second | in
//  result    | m_valid m_ready m_gesture m_key_down           | out
//  config    | cfg_wr_en cfg_index cfg_wdata                  | in
//
// Every input word gives one result word, loaded into the result register when the input register drains.
// One word per cycle is sustained while m_ready holds; the input register and
// the result register each hold one word, and the single pass between them sets the rate.
// A stalled result holds the pipe; the input register still takes one word.
// Synchronous active-low reset clears the counters, flags and both valid bits.
`default_nettype none

module button_click_gesture_detector #(
    parameter int TIME_WIDTH = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_action,
    input  wire                              s_sample_first,
    input  wire                              s_sample_second,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [1:0]                       m_gesture,
    output logic                             m_key_down,
    // configuration
    input  wire                              cfg_wr_en,
    input  wire  [bcgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [bcgd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Comparison width covers both time differences and the widest register
    localparam int CMP_W = (TIME_WIDTH > bcgd_pkg::LONG_W) ? TIME_WIDTH : bcgd_pkg::LONG_W;

    // Configuration registers
    logic [bcgd_pkg::CLICK_MIN_W-1:0] click_min_reg;
    logic [bcgd_pkg::WINDOW_W-1:0]    window_reg;
    logic [bcgd_pkg::LONG_W-1:0]      long_reg;

    // Input register
    logic in_valid_reg;
    logic in_action_reg;
    logic in_first_reg;
    logic in_second_reg;

    // Result register
    logic               out_valid_reg;
    bcgd_pkg::gesture_t gesture_reg;
    logic               key_down_reg;

    // Gesture state
    logic [TIME_WIDTH-1:0] tick_reg,  tick_next;
    logic                  level_reg, level_next;
    logic [TIME_WIDTH-1:0] press1_at_reg,   press1_at_next;
    logic                  press1_seen_reg, press1_seen_next;
    logic [TIME_WIDTH-1:0] rel1_at_reg,     rel1_at_next;
    logic                  rel1_seen_reg,   rel1_seen_next;
    logic [TIME_WIDTH-1:0] press2_at_reg,   press2_at_next;
    logic                  press2_seen_reg, press2_seen_next;
    bcgd_pkg::gesture_t    gesture_next;

    logic advance;
    logic level_in;
    logic [CMP_W-1:0] held_span, press_span, since_rel, press_gap, since_press2;
    logic [CMP_W-1:0] click_min_x, window_x, long_x;
    logic click_hit, double_hit;

    // Handshake: the input register drains whenever the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid    = out_valid_reg;
    assign m_gesture  = gesture_reg;
    assign m_key_down = key_down_reg;

    // Time differences, modulo the counter width
    assign level_in     = in_first_reg && in_second_reg;
    assign held_span    = CMP_W'(TIME_WIDTH'(tick_reg - press1_at_reg));
    assign press_span   = CMP_W'(TIME_WIDTH'(rel1_at_reg - press1_at_reg));
    assign since_rel    = CMP_W'(TIME_WIDTH'(tick_reg - rel1_at_reg));
    assign press_gap    = CMP_W'(TIME_WIDTH'(press2_at_reg - press1_at_reg));
    assign since_press2 = CMP_W'(TIME_WIDTH'(tick_reg - press2_at_reg));
    assign click_min_x  = CMP_W'(click_min_reg);
    assign window_x     = CMP_W'(window_reg);
    assign long_x       = CMP_W'(long_reg);

    // Single click wins over a double click in the same scan
    assign click_hit  = press1_seen_reg && rel1_seen_reg
                        && (press_span >= click_min_x) && (since_rel >= window_x);
    assign double_hit = !click_hit && press1_seen_reg && rel1_seen_reg && press2_seen_reg
                        && (press_gap < window_x) && (press_span >= click_min_x)
                        && (since_press2 >= click_min_x);

    // Classify one word
    always_comb begin
        tick_next        = tick_reg;
        level_next       = level_reg;
        press1_at_next   = press1_at_reg;
        press1_seen_next = press1_seen_reg;
        rel1_at_next     = rel1_at_reg;
        rel1_seen_next   = rel1_seen_reg;
        press2_at_next   = press2_at_reg;
        press2_seen_next = press2_seen_reg;
        gesture_next     = bcgd_pkg::GEST_NONE;

        if (in_action_reg == bcgd_pkg::ACT_TICK) begin
            tick_next = tick_reg + TIME_WIDTH'(1);
        end else if (level_in != level_reg) begin
            // Record the edge time
            level_next = level_in;
            if (level_in) begin
                if (press1_seen_reg) begin
                    press2_at_next   = tick_reg;
                    press2_seen_next = 1'b1;
                end else begin
                    press1_at_next   = tick_reg;
                    press1_seen_next = 1'b1;
                end
            end else if (!rel1_seen_reg) begin
                rel1_at_next   = tick_reg;
                rel1_seen_next = 1'b1;
            end
        end else if (level_in) begin
            // Held: long press
            if (held_span >= long_x) begin
                gesture_next = bcgd_pkg::GEST_LONG;
            end
        end else if (click_hit) begin
            gesture_next = bcgd_pkg::GEST_SINGLE;
        end else if (double_hit) begin
            gesture_next = bcgd_pkg::GEST_DOUBLE;
        end

        // Any gesture clears the times and the counter
        if (gesture_next != bcgd_pkg::GEST_NONE) begin
            tick_next        = '0;
            press1_at_next   = '0;
            press1_seen_next = 1'b0;
            rel1_at_next     = '0;
            rel1_seen_next   = 1'b0;
            press2_at_next   = '0;
            press2_seen_next = 1'b0;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            click_min_reg <= bcgd_pkg::CLICK_MIN_RESET;
            window_reg    <= bcgd_pkg::WINDOW_RESET;
            long_reg      <= bcgd_pkg::LONG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bcgd_pkg::CFG_CLICK_MIN: click_min_reg <= cfg_wdata[bcgd_pkg::CLICK_MIN_W-1:0];
                bcgd_pkg::CFG_WINDOW:    window_reg    <= cfg_wdata[bcgd_pkg::WINDOW_W-1:0];
                bcgd_pkg::CFG_LONG:      long_reg      <= cfg_wdata[bcgd_pkg::LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: take a word whenever it is free or drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= s_action;
            in_first_reg  <= s_sample_first;
            in_second_reg <= s_sample_second;
        end
    end

    // Advance the gesture state and load the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= '0;
            level_reg       <= 1'b0;
            press1_at_reg   <= '0;
            press1_seen_reg <= 1'b0;
            rel1_at_reg     <= '0;
            rel1_seen_reg   <= 1'b0;
            press2_at_reg   <= '0;
            press2_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                tick_reg        <= tick_next;
                level_reg       <= level_next;
                press1_at_reg   <= press1_at_next;
                press1_seen_reg <= press1_seen_next;
                rel1_at_reg     <= rel1_at_next;
                rel1_seen_reg   <= rel1_seen_next;
                press2_at_reg   <= press2_at_next;
                press2_seen_reg <= press2_seen_next;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gesture_reg  <= gesture_next;
            key_down_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bcgd_checker.sv -----
// Port-level checks for the button click gesture detector, bound to the top.
// Depends on bcgd_pkg for the gesture codes.
`default_nettype none

module bcgd_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [1:0] m_gesture,
    input wire       m_key_down
);

    // Hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gesture) && $stable(m_key_down))
        else $error("stalled result word changed");

    // Reset empties the result slot
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty result slot always lets a word in
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with the result slot empty");

    // A long press is only reported while the key is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_gesture == bcgd_pkg::GEST_LONG) |-> m_key_down)
        else $error("long press with key released");

    // Clicks are only reported with the key released
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_gesture == bcgd_pkg::GEST_SINGLE) ||
                    (m_gesture == bcgd_pkg::GEST_DOUBLE)) |-> !m_key_down)
        else $error("click reported with key held");

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_gesture  (m_gesture),
    .m_key_down (m_key_down)
);

`default_nettype wire

// ----- verif/button_click_gesture_detector_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for button_click_gesture_detector: scan and tick words
// under random idling, each result word checked against a gesture predictor.
// Depends on bcgd_pkg and the detector RTL only.

module button_click_gesture_detector_tb;

    localparam int TW          = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SINK_HOLD   = 300;
    localparam int WAIT_CAP    = 300;
    localparam int PRINT_CAP   = 100;
    localparam logic [bcgd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic PIN  = 1'b1;
    localparam logic CALC = 1'b0;

    typedef struct packed {
        bcgd_pkg::gesture_t gesture;
        logic               key_down;
    } verdict_t;

    typedef struct packed {
        logic       act;
        logic       first;
        logic       second;
        logic [7:0] reps;
        logic       pinned;
        verdict_t   want;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_action;
    logic                             s_sample_first;
    logic                             s_sample_second;
    logic                             m_valid;
    logic                             m_ready;
    logic [1:0]                       m_gesture;
    logic                             m_key_down;
    logic                             cfg_wr_en;
    logic [bcgd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bcgd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Predictor copy of the registers and the recorded times
    logic [7:0]    click_min;
    logic [7:0]    window;
    logic [15:0]   long_limit;
    logic [TW-1:0] now_ticks;
    logic [TW-1:0] press1_at;
    logic [TW-1:0] release1_at;
    logic [TW-1:0] press2_at;
    logic          press1_seen;
    logic          release1_seen;
    logic          press2_seen;
    logic          level_was;

    verdict_t gesture_due[$];
    int       mismatches;
    int       cycles;
    int       words_sent;
    bit       tx_idle;
    bit       rx_idle;
    bit       calm;
    bit       sink_hold_req;
    logic     cur_pinned;
    verdict_t cur_want;

    // Directed words, run with the reset settings (click 1, window 10, long 40)
    stim_row_t dir_rows [] = '{
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        // double click: press, release, press, release, then a quiet scan
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_TICK, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_DOUBLE, 1'b0}},
        // single click: one tick short of the window, then on it
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_TICK, 1'b1, 1'b0, 8'd3,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b0, 8'd9,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_TICK, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_SINGLE, 1'b0}},
        // long press, one tick short and then on the limit, then repeated
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b0, 8'd39, PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_LONG,   1'b1}},
        '{bcgd_pkg::ACT_TICK, 1'b1, 1'b1, 8'd40, PIN,  '{bcgd_pkg::GEST_NONE,   1'b1}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  PIN,  '{bcgd_pkg::GEST_LONG,   1'b1}},
        // release recorded before any press, so the press length wraps
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b0, 8'd1,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b0, 8'd5,  PIN,  '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b0, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_TICK, 1'b0, 1'b1, 8'd10, CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b1, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        // press too short for a click, then a second press
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b0, 1'b0, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_TICK, 1'b1, 1'b0, 8'd12, CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b0, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}},
        '{bcgd_pkg::ACT_SCAN, 1'b1, 1'b1, 8'd1,  CALC, '{bcgd_pkg::GEST_NONE,   1'b0}}
    };

    button_click_gesture_detector #(
        .TIME_WIDTH(TW)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_sample_first  (s_sample_first),
        .s_sample_second (s_sample_second),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gesture       (m_gesture),
        .m_key_down      (m_key_down),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Give up once the run is far beyond any correct duration
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("button_click_gesture_detector_tb NOT OK");
            $finish;
        end
    end

    // Drop every recorded time and restart the tick count
    function automatic void forget_times();
        now_ticks     = '0;
        press1_at     = '0;
        press1_seen   = 1'b0;
        release1_at   = '0;
        release1_seen = 1'b0;
        press2_at     = '0;
        press2_seen   = 1'b0;
    endfunction

    // Advance the predicted state by one word and return the result it gives
    function automatic verdict_t classify_word(logic act, logic first, logic second);
        logic          level;
        logic [TW-1:0] held;
        logic [TW-1:0] since;
        logic [TW-1:0] gap;
        logic [TW-1:0] since2;
        verdict_t      v;
        v.gesture = bcgd_pkg::GEST_NONE;
        if (act == bcgd_pkg::ACT_TICK) begin
            now_ticks = now_ticks + 1'b1;
        end else begin
            level = first & second;
            if (level != level_was) begin
                level_was = level;
                if (level) begin
                    if (press1_seen) begin
                        press2_at   = now_ticks;
                        press2_seen = 1'b1;
                    end else begin
                        press1_at   = now_ticks;
                        press1_seen = 1'b1;
                    end
                end else if (!release1_seen) begin
                    release1_at   = now_ticks;
                    release1_seen = 1'b1;
                end
            end else if (level) begin
                // a held key repeats the long press from the cleared time
                held = now_ticks - press1_at;
                if (held >= long_limit) begin
                    v.gesture = bcgd_pkg::GEST_LONG;
                    forget_times();
                end
            end else begin
                held   = release1_at - press1_at;
                since  = now_ticks - release1_at;
                gap    = press2_at - press1_at;
                since2 = now_ticks - press2_at;
                if (press1_seen && release1_seen && held >= click_min && since >= window) begin
                    v.gesture = bcgd_pkg::GEST_SINGLE;
                    forget_times();
                end
                // the single click clears the flags, so no double can follow it
                if (press1_seen && release1_seen && press2_seen && gap < window
                        && held >= click_min && since2 >= click_min) begin
                    v.gesture = bcgd_pkg::GEST_DOUBLE;
                    forget_times();
                end
            end
        end
        v.key_down = level_was;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Check each result word against the oldest one due, then record new words
    always @(posedge aclk) begin : gesture_check
        verdict_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (gesture_due.size() == 0) begin
                    report_mismatch("result word with none due", m_gesture, -1);
                end else begin
                    want = gesture_due.pop_front();
                    if (m_gesture != want.gesture)
                        report_mismatch("gesture", m_gesture, want.gesture);
                    if (m_key_down != want.key_down)
                        report_mismatch("key_down", m_key_down, want.key_down);
                end
            end
            if (s_valid && s_ready) begin
                want = classify_word(s_action, s_sample_first, s_sample_second);
                if (cur_pinned)
                    want = cur_want;
                gesture_due.push_back(want);
            end
        end
    end

    // Result side: random stall bursts, plus one long hold on request
    initial begin : result_sink
        int hold_left;
        int gap_left;
        m_ready   = 1'b0;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                hold_left     = SINK_HOLD;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until taken; maybe idle afterwards
    task automatic send_word(input logic act, input logic first, input logic second,
                             input logic pinned = CALC, input verdict_t want = '0);
        s_valid         <= 1'b1;
        s_action        <= act;
        s_sample_first  <= first;
        s_sample_second <= second;
        cur_pinned      <= pinned;
        cur_want        <= want;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Scan at a given level; a released key shows any non-pressed sample pair
    task automatic scan_level(input logic level);
        int pick;
        if (level) begin
            send_word(bcgd_pkg::ACT_SCAN, 1'b1, 1'b1);
        end else begin
            pick = $urandom_range(0, 2);
            send_word(bcgd_pkg::ACT_SCAN, pick == 1, pick == 2);
        end
    endtask

    // Let n ticks pass, scanning now and then at the same level
    task automatic hold_for(input int n, input logic level);
        for (int i = 0; i < n; i++) begin
            send_word(bcgd_pkg::ACT_TICK, $urandom_range(0, 1) == 1,
                      $urandom_range(0, 1) == 1);
            if ($urandom_range(0, 1) == 0)
                scan_level(level);
        end
    endtask

    // Tick count close to a threshold, either side of it
    function automatic int near(input int v);
        int n;
        n = v - 1 + int'($urandom_range(0, 3));
        if (n < 0)
            n = 0;
        if (n > WAIT_CAP)
            n = WAIT_CAP;
        return n;
    endfunction

    // One gesture attempt with random timing, or a short run of noise
    task automatic play_gesture();
        int kind;
        if (!calm && $urandom_range(0, 7) == 0) begin
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
        end
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                scan_level(1'b1);
                hold_for(near(click_min), 1'b1);
                scan_level(1'b0);
                hold_for(near(window), 1'b0);
                scan_level(1'b0);
                scan_level(1'b0);
            end
            3, 4, 5: begin
                scan_level(1'b1);
                hold_for(near(click_min), 1'b1);
                scan_level(1'b0);
                hold_for($urandom_range(0, window), 1'b0);
                scan_level(1'b1);
                // a third press overwrites the second press time
                if ($urandom_range(0, 3) == 0) begin
                    scan_level(1'b0);
                    scan_level(1'b1);
                end
                hold_for(near(click_min), 1'b1);
                scan_level(1'b0);
                scan_level(1'b0);
                hold_for($urandom_range(0, 2), 1'b0);
                scan_level(1'b0);
            end
            6, 7: begin
                scan_level(1'b1);
                hold_for(near(long_limit), 1'b1);
                scan_level(1'b1);
                if ($urandom_range(0, 1) == 0) begin
                    hold_for(near(long_limit), 1'b1);
                    scan_level(1'b1);
                end
                scan_level(1'b0);
            end
            default: begin
                repeat ($urandom_range(1, 6))
                    send_word($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                              $urandom_range(0, 1) == 1);
            end
        endcase
    endtask

    task automatic run_gestures(input int n);
        int stop_at;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
            play_gesture();
    endtask

    // Stop offering words and wait until every result has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (gesture_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write all registers while idle; the spare index takes junk and is ignored
    task automatic set_config(input logic [7:0] cm, input logic [7:0] win,
                              input logic [15:0] lp);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_index <= bcgd_pkg::CFG_CLICK_MIN;
        cfg_wdata <= {8'($urandom), cm};
        @(posedge aclk);
        cfg_index <= bcgd_pkg::CFG_WINDOW;
        cfg_wdata <= {8'($urandom), win};
        @(posedge aclk);
        cfg_index <= bcgd_pkg::CFG_LONG;
        cfg_wdata <= lp;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        click_min  = cm;
        window     = win;
        long_limit = lp;
    endtask

    initial begin : stimulus
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_action        = bcgd_pkg::ACT_SCAN;
        s_sample_first  = 1'b0;
        s_sample_second = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = bcgd_pkg::CFG_CLICK_MIN;
        cfg_wdata       = '0;
        cur_pinned      = CALC;
        cur_want        = '0;
        sink_hold_req   = 1'b0;
        calm            = 1'b0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        click_min       = 8'd1;
        window          = 8'd10;
        long_limit      = 16'd40;
        level_was       = 1'b0;
        forget_times();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset settings
        foreach (dir_rows[r])
            repeat (dir_rows[r].reps)
                send_word(dir_rows[r].act, dir_rows[r].first, dir_rows[r].second,
                          dir_rows[r].pinned, dir_rows[r].want);

        // all thresholds at zero; hold the result side off to fill the pipe
        set_config(8'd0, 8'd0, 16'd0);
        run_gestures(200);
        sink_hold_req = 1'b1;
        run_gestures(60);

        set_config(8'd2, 8'd4, 16'd6);
        run_gestures(250);

        // mid-range thresholds
        set_config(8'd3, 8'd6, 16'd12);
        run_gestures(250);

        // largest settings: only a few slow gestures
        set_config(8'd255, 8'd255, 16'd65535);
        run_gestures(100);

        set_config(8'($urandom_range(0, 4)), 8'($urandom_range(0, 8)),
                   16'($urandom_range(0, 15)));
        run_gestures(150);
        calm    = 1'b1;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_gestures(150);

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("button_click_gesture_detector_tb OK");
        end else begin
            $display("button_click_gesture_detector_tb NOT OK");
        end
        $finish;
    end

endmodule
